FILE: src/lsqe_pkg.sv
// ----------------------------------------------------------------------------
// lsqe_pkg: shared types, constants and tables
// parse phases, result kinds, character codes, calendar tables and the
// control bundle handed from the byte parser to the epoch accumulator
// ----------------------------------------------------------------------------
package lsqe_pkg;

	typedef enum logic [3:0] {
		PH_DAY    = 4'd0,
		PH_MON    = 4'd1,
		PH_YEAR   = 4'd2,
		PH_HOUR   = 4'd3,
		PH_MIN    = 4'd4,
		PH_SEC    = 4'd5,
		PH_MILLI  = 4'd6,
		PH_SEEK   = 4'd7,
		PH_DOMAIN = 4'd8,
		PH_SKIP   = 4'd9,
		PH_DONE   = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		KIND_STAMP   = 3'd0,
		KIND_CHAR    = 3'd1,
		KIND_END     = 3'd2,
		KIND_NOQUERY = 3'd3,
		KIND_BAD     = 3'd4
	} kind_t;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_Q     = 8'h71;

	// calendar limits
	localparam int         EPOCH_YEAR_I = 1970;
	localparam logic [11:0] EPOCH_YEAR  = 12'(EPOCH_YEAR_I);
	localparam logic [11:0] LAST_YEAR   = 12'd2099;
	localparam logic [8:0]  LEAP_BASE   = 9'((EPOCH_YEAR_I - 1) / 4);
	localparam logic [4:0]  DAY_MAX     = 5'd31;
	localparam logic [4:0]  FEB_LEAP    = 5'd29;
	localparam logic [3:0]  MONTH_FEB   = 4'd2;
	localparam logic [5:0]  HOUR_MAX    = 6'd23;
	localparam logic [5:0]  MINSEC_MAX  = 6'd59;
	localparam logic [2:0]  KW_LAST     = 3'd6;

	// time scales in microseconds
	localparam logic [31:0] SEC_US  = 32'd1000000;
	localparam logic [31:0] MIN_US  = SEC_US * 32'd60;
	localparam logic [31:0] HOUR_US = SEC_US * 32'd3600;
	localparam logic [51:0] DAY_US  = 52'd86400 * 52'd1000000;
	localparam logic [19:0] MS_US   = 20'd1000;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] ch;
	} res_t;

	typedef struct packed {
		logic        load_days;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        add_hour;
		logic        add_min;
		logic        add_sec;
		logic [5:0]  tval;
		logic [9:0]  milli;
	} ep_ctl_t;

	// 1..12, 0 when the three letters name no month
	function automatic logic [3:0] month_of(input logic [23:0] w);
		logic [3:0] m;
		unique case (w)
			"Jan":   m = 4'd1;
			"Feb":   m = 4'd2;
			"Mar":   m = 4'd3;
			"Apr":   m = 4'd4;
			"May":   m = 4'd5;
			"Jun":   m = 4'd6;
			"Jul":   m = 4'd7;
			"Aug":   m = 4'd8;
			"Sep":   m = 4'd9;
			"Oct":   m = 4'd10;
			"Nov":   m = 4'd11;
			"Dec":   m = 4'd12;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd2:                     d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                  d = 5'd31;
		endcase
		return d;
	endfunction

	// "query: "
	function automatic logic [7:0] keyword_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = "q";
			3'd1:    c = "u";
			3'd2:    c = "e";
			3'd3:    c = "r";
			3'd4:    c = "y";
			3'd5:    c = ":";
			3'd6:    c = " ";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: src/log_stamp_and_query_extractor_top.sv
// ----------------------------------------------------------------------------
// log_stamp_and_query_extractor_top: log line stamp and query extractor
// parses a leading DD-Mon-YYYY HH:MM:SS.mmm stamp into microseconds since
// 1970, then passes through the domain after "query: " one byte per item
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | line_byte
//  out     | out_valid/out_ready| item_kind, epoch_micros, domain_char
//
// one byte per cycle while in_ready is high; a byte's result (if any) is
// registered in the output register, or in the skid entry if out stalls.
// the stamp value is built up field by field as the bytes arrive, so the
// last millisecond digit only adds the millisecond term. reset puts the
// parser at line start, day field, with the output empty. an output register
// plus one skid entry: a stalled out channel still lets one more byte in;
// in_ready is a register and drops only while the skid entry is full.
// ----------------------------------------------------------------------------
module log_stamp_and_query_extractor_top
	import lsqe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  line_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  item_kind,
	output logic [51:0] epoch_micros,
	output logic [7:0]  domain_char
);

	logic        accept;
	res_t        res;
	ep_ctl_t     ep;
	logic [51:0] ep_micros;
	logic        res_v;
	logic        out_free;
	logic [51:0] res_micros;

	// output register and skid entry
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [51:0] out_micros_q;
	logic [7:0]  out_char_q;
	logic        sk_valid_q;
	kind_t       sk_kind_q;
	logic [51:0] sk_micros_q;
	logic [7:0]  sk_char_q;

	assign in_ready = !sk_valid_q;
	assign accept   = in_valid && in_ready;

	lsqe_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.line_byte (line_byte),
		.res       (res),
		.ep        (ep)
	);

	lsqe_epoch u_epoch (
		.clk    (clk),
		.ep     (ep),
		.micros (ep_micros)
	);

	// stamp value rides only on stamp items
	assign res_micros = (res.kind == KIND_STAMP) ? ep_micros : 52'd0;
	assign res_v      = accept && res.valid;
	assign out_free   = !out_valid_q || out_ready;

	// control: output slot and skid slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (out_free) begin
			// skid entry drains first; no new byte was taken while it was full
			out_valid_q <= sk_valid_q || res_v;
			sk_valid_q  <= 1'b0;
		end else if (res_v) begin
			sk_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (sk_valid_q) begin
				out_kind_q   <= sk_kind_q;
				out_micros_q <= sk_micros_q;
				out_char_q   <= sk_char_q;
			end else if (res_v) begin
				out_kind_q   <= res.kind;
				out_micros_q <= res_micros;
				out_char_q   <= res.ch;
			end
		end else if (res_v) begin
			sk_kind_q   <= res.kind;
			sk_micros_q <= res_micros;
			sk_char_q   <= res.ch;
		end
	end

	assign out_valid    = out_valid_q;
	assign item_kind    = out_kind_q;
	assign epoch_micros = out_micros_q;
	assign domain_char  = out_char_q;

endmodule

FILE: src/lsqe_parse.sv
// ----------------------------------------------------------------------------
// lsqe_parse: per-byte line parser
// stamp field checks, keyword search and domain pass-through; one byte per
// accepted item, result and epoch controls formed combinationally
// ----------------------------------------------------------------------------
module lsqe_parse
	import lsqe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] line_byte,
	output res_t       res,
	output ep_ctl_t    ep
);

	phase_t      phase_q, phase_d;
	logic [1:0]  dc_q, dc_d;
	logic [4:0]  day_q, day_d;
	logic [23:0] mon_q, mon_d;
	logic [11:0] year_q, year_d;
	logic [4:0]  hour_q, hour_d;
	logic [5:0]  min_q, min_d;
	logic [5:0]  sec_q, sec_d;
	logic [9:0]  milli_q, milli_d;
	logic [2:0]  kw_q, kw_d;

	logic        is_eol, is_dig;
	logic [7:0]  dsub;
	logic [3:0]  dv;
	logic [8:0]  day_nv;
	logic [3:0]  mon_code;
	logic [14:0] yr_nv;
	logic [4:0]  day_lim;
	logic [5:0]  tv, t_lim;
	logic [7:0]  t_sep;
	logic [9:0]  t_nv;
	logic [13:0] mi_nv;
	logic [7:0]  kw_c;

	logic day_dig, day_dig_ok, day_sep, mon_let, mon_sep;
	logic yr_dig_ok, yr_sep, t_dig, t_dig_ok, t_sep_ok, mi_last, kw_hit, kw_done;

	assign is_eol   = (line_byte == CH_NL) || (line_byte == CH_CR) || (line_byte == CH_NUL);
	assign is_dig   = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
	assign dsub     = line_byte - CH_ZERO;
	assign dv       = dsub[3:0];
	assign day_nv   = 9'(day_q) * 9'd10 + 9'(dv);
	assign mon_code = month_of(mon_q);
	assign yr_nv    = 15'(year_q) * 15'd10 + 15'(dv);
	assign t_nv     = 10'(tv) * 10'd10 + 10'(dv);
	assign mi_nv    = 14'(milli_q) * 14'd10 + 14'(dv);
	assign kw_c     = keyword_char(kw_q);

	// february grows a day in years divisible by four
	always_comb begin
		day_lim = month_len(mon_code);
		if (mon_code == MONTH_FEB && year_q[1:0] == 2'd0) begin
			day_lim = FEB_LEAP;
		end
	end

	// the time field in work, its limit and its closing separator
	always_comb begin
		case (phase_q)
			PH_HOUR: begin
				tv    = {1'b0, hour_q};
				t_lim = HOUR_MAX;
				t_sep = CH_COLON;
			end
			PH_MIN: begin
				tv    = min_q;
				t_lim = MINSEC_MAX;
				t_sep = CH_COLON;
			end
			default: begin
				tv    = sec_q;
				t_lim = MINSEC_MAX;
				t_sep = CH_DOT;
			end
		endcase
	end

	assign day_dig    = is_dig && (dc_q < 2'd2);
	assign day_dig_ok = day_dig && (day_nv <= 9'(DAY_MAX));
	assign day_sep    = (line_byte == CH_DASH) && (dc_q != 2'd0) && (day_q != 5'd0);
	assign mon_let    = (line_byte != CH_DASH) && (dc_q != 2'd3);
	assign mon_sep    = (line_byte == CH_DASH) && (dc_q == 2'd3) && (mon_code != 4'd0);
	assign yr_dig_ok  = is_dig && !(year_q == 12'd0 && line_byte == CH_ZERO)
			&& (yr_nv <= 15'(LAST_YEAR));
	assign yr_sep     = (line_byte == CH_SPACE) && (year_q >= EPOCH_YEAR)
			&& (mon_code != 4'd0) && (day_q <= day_lim);
	assign t_dig      = is_dig && (dc_q < 2'd2);
	assign t_dig_ok   = t_dig && (t_nv <= 10'(t_lim));
	assign t_sep_ok   = (line_byte == t_sep) && (dc_q == 2'd2);
	assign mi_last    = (dc_q == 2'd2);
	assign kw_hit     = (line_byte == kw_c);
	assign kw_done    = kw_hit && (kw_q == KW_LAST);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (is_eol) begin
			phase_d = PH_DAY;
		end else begin
			unique case (phase_q)
				PH_DAY: begin
					if (day_dig)      phase_d = day_dig_ok ? PH_DAY : PH_SKIP;
					else if (day_sep) phase_d = PH_MON;
					else              phase_d = PH_SKIP;
				end
				PH_MON: begin
					if (mon_let)      phase_d = PH_MON;
					else if (mon_sep) phase_d = PH_YEAR;
					else              phase_d = PH_SKIP;
				end
				PH_YEAR: begin
					if (is_dig)      phase_d = yr_dig_ok ? PH_YEAR : PH_SKIP;
					else if (yr_sep) phase_d = PH_HOUR;
					else             phase_d = PH_SKIP;
				end
				PH_HOUR: begin
					if (t_dig)         phase_d = t_dig_ok ? PH_HOUR : PH_SKIP;
					else if (t_sep_ok) phase_d = PH_MIN;
					else               phase_d = PH_SKIP;
				end
				PH_MIN: begin
					if (t_dig)         phase_d = t_dig_ok ? PH_MIN : PH_SKIP;
					else if (t_sep_ok) phase_d = PH_SEC;
					else               phase_d = PH_SKIP;
				end
				PH_SEC: begin
					if (t_dig)         phase_d = t_dig_ok ? PH_SEC : PH_SKIP;
					else if (t_sep_ok) phase_d = PH_MILLI;
					else               phase_d = PH_SKIP;
				end
				PH_MILLI: begin
					if (!is_dig)      phase_d = PH_SKIP;
					else if (mi_last) phase_d = PH_SEEK;
				end
				PH_SEEK: begin
					if (kw_done) phase_d = PH_DOMAIN;
				end
				PH_DOMAIN: begin
					if (line_byte == CH_SPACE) phase_d = PH_DONE;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// field updates, result and epoch controls
	always_comb begin
		dc_d    = dc_q;
		day_d   = day_q;
		mon_d   = mon_q;
		year_d  = year_q;
		hour_d  = hour_q;
		min_d   = min_q;
		sec_d   = sec_q;
		milli_d = milli_q;
		kw_d    = kw_q;
		res       = '{valid: 1'b0, kind: KIND_STAMP, ch: 8'h00};
		ep.load_days = 1'b0;
		ep.add_hour  = 1'b0;
		ep.add_min   = 1'b0;
		ep.add_sec   = 1'b0;
		ep.year      = year_q;
		ep.month     = mon_code;
		ep.day       = day_q;
		ep.tval      = tv;
		ep.milli     = mi_nv[9:0];
		if (is_eol) begin
			dc_d    = '0;
			day_d   = '0;
			mon_d   = '0;
			year_d  = '0;
			hour_d  = '0;
			min_d   = '0;
			sec_d   = '0;
			milli_d = '0;
			kw_d    = '0;
			// an empty line gives nothing
			if (phase_q == PH_DAY && dc_q == 2'd0) begin
				res.valid = 1'b0;
			end else if (phase_q <= PH_MILLI) begin
				res.valid = 1'b1;
				res.kind  = KIND_BAD;
			end else if (phase_q == PH_SEEK) begin
				res.valid = 1'b1;
				res.kind  = KIND_NOQUERY;
			end else if (phase_q == PH_DOMAIN) begin
				res.valid = 1'b1;
				res.kind  = KIND_END;
			end
		end else begin
			unique case (phase_q)
				PH_DAY: begin
					if (day_dig) begin
						day_d = day_nv[4:0];
						dc_d  = 2'(dc_q + 2'd1);
					end else if (day_sep) begin
						dc_d = 2'd0;
					end
				end
				PH_MON: begin
					if (mon_let) begin
						mon_d = {mon_q[15:0], line_byte};
						dc_d  = 2'(dc_q + 2'd1);
					end else if (mon_sep) begin
						dc_d = 2'd0;
					end
				end
				PH_YEAR: begin
					if (is_dig) begin
						year_d = yr_nv[11:0];
					end else if (yr_sep) begin
						dc_d         = 2'd0;
						ep.load_days = accept;
					end
				end
				PH_HOUR: begin
					if (t_dig) begin
						hour_d = t_nv[4:0];
						dc_d   = 2'(dc_q + 2'd1);
					end else if (t_sep_ok) begin
						dc_d        = 2'd0;
						ep.add_hour = accept;
					end
				end
				PH_MIN: begin
					if (t_dig) begin
						min_d = t_nv[5:0];
						dc_d  = 2'(dc_q + 2'd1);
					end else if (t_sep_ok) begin
						dc_d       = 2'd0;
						ep.add_min = accept;
					end
				end
				PH_SEC: begin
					if (t_dig) begin
						sec_d = t_nv[5:0];
						dc_d  = 2'(dc_q + 2'd1);
					end else if (t_sep_ok) begin
						dc_d       = 2'd0;
						ep.add_sec = accept;
					end
				end
				PH_MILLI: begin
					if (is_dig) begin
						milli_d = mi_nv[9:0];
						if (mi_last) begin
							dc_d      = 2'd0;
							kw_d      = 3'd0;
							res.valid = 1'b1;
							res.kind  = KIND_STAMP;
						end else begin
							dc_d = 2'(dc_q + 2'd1);
						end
					end
				end
				PH_SEEK: begin
					if (kw_hit) begin
						kw_d = kw_done ? 3'd0 : 3'(kw_q + 3'd1);
					end else begin
						kw_d = (line_byte == CH_Q) ? 3'd1 : 3'd0;
					end
				end
				PH_DOMAIN: begin
					res.valid = 1'b1;
					if (line_byte == CH_SPACE) begin
						res.kind = KIND_END;
					end else begin
						res.kind = KIND_CHAR;
						res.ch   = line_byte;
					end
				end
				default: res.valid = 1'b0;
			endcase
			// first byte that breaks the stamp grammar
			if (phase_d == PH_SKIP && phase_q != PH_SKIP) begin
				res.valid = 1'b1;
				res.kind  = KIND_BAD;
				res.ch    = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DAY;
			dc_q    <= '0;
			day_q   <= '0;
			mon_q   <= '0;
			year_q  <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			milli_q <= '0;
			kw_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			dc_q    <= dc_d;
			day_q   <= day_d;
			mon_q   <= mon_d;
			year_q  <= year_d;
			hour_q  <= hour_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			milli_q <= milli_d;
			kw_q    <= kw_d;
		end
	end

endmodule

FILE: src/lsqe_epoch.sv
// ----------------------------------------------------------------------------
// lsqe_epoch: stamp to microseconds accumulator
// day count at the year separator, then one scaled term added per time field,
// milliseconds folded in on the last digit
// ----------------------------------------------------------------------------
module lsqe_epoch
	import lsqe_pkg::*;
(
	input  logic        clk,
	input  ep_ctl_t     ep,
	output logic [51:0] micros
);

	logic [11:0] ydiff, ym1;
	logic [9:0]  lp9;
	logic        leap_now;
	logic [15:0] days_calc;
	logic [15:0] days_q;
	logic [51:0] day_us_q;
	logic [51:0] acc_q;
	logic [31:0] tmul;
	logic [37:0] tprod;
	logic [51:0] base;
	logic [19:0] ms_prod;

	// whole days since the epoch, leap days of earlier years plus this one
	assign ydiff    = ep.year - EPOCH_YEAR;
	assign ym1      = ep.year - 12'd1;
	assign lp9      = ym1[11:2] - 10'(LEAP_BASE);
	assign leap_now = (ep.year[1:0] == 2'd0) && (ep.month > MONTH_FEB);
	assign days_calc = 16'(ydiff[7:0]) * 16'd365 + 16'(days_before(ep.month))
			+ 16'(lp9[5:0]) + 16'(leap_now) + 16'(ep.day) - 16'd1;

	always_ff @(posedge clk) begin
		if (ep.load_days) begin
			days_q <= days_calc;
		end
	end

	// free-running scale; settled well before the hour separator arrives
	always_ff @(posedge clk) begin
		day_us_q <= 52'(days_q) * DAY_US;
	end

	always_comb begin
		if (ep.add_hour)     tmul = HOUR_US;
		else if (ep.add_min) tmul = MIN_US;
		else                 tmul = SEC_US;
	end

	assign tprod = 38'(ep.tval) * 38'(tmul);
	assign base  = ep.add_hour ? day_us_q : acc_q;

	always_ff @(posedge clk) begin
		if (ep.add_hour || ep.add_min || ep.add_sec) begin
			acc_q <= base + 52'(tprod);
		end
	end

	assign ms_prod = 20'(ep.milli) * MS_US;
	assign micros  = acc_q + 52'(ms_prod);

endmodule
